// ----- src/pmc_pkg.sv -----
package pmc_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam logic [31:0] PROBE_INTERVAL_RST = 32'd600000;

  localparam int unsigned PLATEAUS = 11;
  localparam logic [15:0] MIN_MTU = 16'd68;
  localparam logic [15:0] PLATEAU [PLATEAUS] = '{
    16'd65535, 16'd32000, 16'd17914, 16'd8166, 16'd4352, 16'd2002,
    16'd1492, 16'd1006, 16'd508, 16'd296, 16'd68
  };

  typedef enum logic [1:0] {
    FN_UPDATE     = 2'd0,
    FN_LOOKUP     = 2'd1,
    FN_NEXT_LOWER = 2'd2
  } pmc_func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } pmc_state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] mtu;
    logic [31:0] stamp;
  } pmc_entry_t;

  typedef struct packed {
    logic        status;
    logic        hit;
    logic [15:0] mtu_out;
    logic        probe_due;
  } pmc_rsp_t;

  function automatic logic [15:0] lower_plateau(input logic [15:0] cur);
    logic [15:0] res;
    logic        found;
    res   = MIN_MTU;
    found = 1'b0;
    for (int i = 0; i < PLATEAUS; i++) begin
      if (!found && (PLATEAU[i] < cur)) begin
        res   = PLATEAU[i];
        found = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// ----- src/pmc_if.sv -----
interface pmc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] dest;
  logic [15:0] mtu;
  logic [31:0] now;

  modport source (output valid, output func, output dest, output mtu, output now,
                  input ready);
  modport sink   (input valid, input func, input dest, input mtu, input now,
                  output ready);
endinterface

interface pmc_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        hit;
  logic [15:0] mtu_out;
  logic        probe_due;

  modport source (output valid, output status, output hit, output mtu_out,
                  output probe_due, input ready);
  modport sink   (input valid, input status, input hit, input mtu_out,
                  input probe_due, output ready);
endinterface

// ----- src/pmc_table.sv -----
module pmc_table #(
  parameter int unsigned ENTRIES = pmc_pkg::ENTRIES_DEF,
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  pmc_pkg::pmc_entry_t wr_data,
  input  logic [IDX_W-1:0]    rd_addr,
  output pmc_pkg::pmc_entry_t rd_data
);

  pmc_pkg::pmc_entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/pmc_seq.sv -----
module pmc_seq #(
  parameter int unsigned ENTRIES = pmc_pkg::ENTRIES_DEF,
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  pmc_req_if.sink             req,
  pmc_rsp_if.source           rsp,
  input  logic [31:0]         probe_period,
  output logic [IDX_W-1:0]    rd_addr,
  input  pmc_pkg::pmc_entry_t rd_data,
  output logic                wr_en,
  output logic [IDX_W-1:0]    wr_addr,
  output pmc_pkg::pmc_entry_t wr_data,
  output logic [CNT_W-1:0]    count
);

  pmc_pkg::pmc_state_t state, state_next;
  logic [1:0]          func_q;
  logic [31:0]         dest_q;
  logic [15:0]         mtu_q;
  logic [31:0]         now_q;
  logic [CNT_W-1:0]    idx;
  logic                cmp_valid;
  logic [IDX_W-1:0]    cmp_idx;
  pmc_pkg::pmc_rsp_t   res;

  logic        match;
  logic        scan_done;
  logic        full;
  logic [31:0] elapsed;
  logic        due;
  logic        is_update;
  logic        req_scan;

  assign match     = cmp_valid && (rd_data.key == dest_q);
  assign scan_done = match || (idx == count);
  assign full      = (count == CNT_W'(ENTRIES));
  assign elapsed   = now_q - rd_data.stamp;
  assign due       = (elapsed >= probe_period);
  assign is_update = (func_q == 2'(pmc_pkg::FN_UPDATE));
  assign req_scan  = (req.func == 2'(pmc_pkg::FN_UPDATE)) ||
                     (req.func == 2'(pmc_pkg::FN_LOOKUP));

  always_comb begin
    state_next = state;
    unique case (state)
      pmc_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = req_scan ? pmc_pkg::ST_SCAN : pmc_pkg::ST_RESP;
        end
      end
      pmc_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = pmc_pkg::ST_RESP;
        end
      end
      pmc_pkg::ST_RESP: begin
        if (rsp.ready) begin
          state_next = pmc_pkg::ST_IDLE;
        end
      end
      default: state_next = pmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready     = (state == pmc_pkg::ST_IDLE);
    rsp.valid     = (state == pmc_pkg::ST_RESP);
    rsp.status    = res.status;
    rsp.hit       = res.hit;
    rsp.mtu_out   = res.mtu_out;
    rsp.probe_due = res.probe_due;
    rd_addr       = idx[IDX_W-1:0];
    wr_en         = (state == pmc_pkg::ST_SCAN) && scan_done && is_update &&
                    (match || !full);
    wr_addr       = match ? cmp_idx : count[IDX_W-1:0];
    wr_data.key   = dest_q;
    wr_data.mtu   = mtu_q;
    wr_data.stamp = now_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pmc_pkg::ST_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        pmc_pkg::ST_IDLE: begin
          if (req.valid) begin
            func_q    <= req.func;
            dest_q    <= req.dest;
            mtu_q     <= req.mtu;
            now_q     <= req.now;
            idx       <= '0;
            cmp_valid <= 1'b0;
            res       <= '{status: 1'b0, hit: 1'b0,
                          mtu_out: (req.func == 2'(pmc_pkg::FN_NEXT_LOWER)) ?
                                   pmc_pkg::lower_plateau(req.mtu) : 16'd0,
                          probe_due: 1'b0};
          end
        end
        pmc_pkg::ST_SCAN: begin
          if (scan_done) begin
            cmp_valid <= 1'b0;
            if (is_update) begin
              res <= '{status: !match && full, hit: match, mtu_out: 16'd0,
                       probe_due: 1'b0};
              if (!match && !full) begin
                count <= count + CNT_W'(1);
              end
            end else begin
              res <= '{status: 1'b0, hit: match,
                       mtu_out: match ? rd_data.mtu : 16'd0,
                       probe_due: match && due};
            end
          end else begin
            idx       <= idx + CNT_W'(1);
            cmp_valid <= 1'b1;
            cmp_idx   <= idx[IDX_W-1:0];
          end
        end
        pmc_pkg::ST_RESP: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/path_mtu_cache.sv -----
// Path MTU table, keyed by 32-bit destination address.
// req channel: one beat per operation (func, dest, mtu, now). func selects
//   update, lookup or next-lower plateau; other codes answer all zeros.
// rsp channel: one beat per request (status, hit, mtu_out, probe_due).
// cfg_we/cfg_wdata write the probe period; write only while the block is idle.
// One request at a time: req.ready is high only in idle, so no request is
// taken while one is in work or a response is pending. Update and lookup scan
// the table one entry per cycle through the registered read port of the entry
// memory, first match wins. A miss scans all stored entries before the
// response beat is offered, and a match ends the scan at that entry;
// next-lower and undefined codes go straight from idle to the response.
// Response beats hold in the output register while rsp.ready is low, and no
// new request is taken until that beat leaves.
// Reset empties the table at once (entry count to zero, no clearing pass)
// and sets the probe period to 600000 ticks.
module path_mtu_cache #(
  parameter int unsigned ENTRIES = pmc_pkg::ENTRIES_DEF,
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic        clk,
  input  logic        rst,
  pmc_req_if.sink     req,
  pmc_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]         probe_period;
  logic [IDX_W-1:0]    rd_addr;
  pmc_pkg::pmc_entry_t rd_data;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  pmc_pkg::pmc_entry_t wr_data;
  logic [CNT_W-1:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_period <= pmc_pkg::PROBE_INTERVAL_RST;
    end else if (cfg_we) begin
      probe_period <= cfg_wdata;
    end
  end

  pmc_table #(.ENTRIES(ENTRIES)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pmc_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .rsp          (rsp),
    .probe_period (probe_period),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .count        (count)
  );

  a_ready_no_pending: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid)
    else $error("request taken while a response is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("ready still high after accept");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count beyond table depth");

  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status) |-> (!rsp.hit && count == CNT_W'(ENTRIES)))
    else $error("full status with hit or free slot");

  a_due_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.probe_due) |-> rsp.hit)
    else $error("probe due without hit");

endmodule

// ----- tb/path_mtu_cache_tb.sv -----
module path_mtu_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FN_UNDEF = 2'd3;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned KEY_POOL = 24;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_OPS = 305;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] dest;
    logic [15:0] mtu;
    logic [31:0] now;
  } pmtu_op_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  pmc_req_if req_bus ();
  pmc_rsp_if rsp_bus ();

  path_mtu_cache u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_bus),
    .rsp       (rsp_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // mirror of the MTU table and the probe interval
  logic [31:0] tbl_key   [pmc_pkg::ENTRIES_DEF];
  logic [15:0] tbl_mtu   [pmc_pkg::ENTRIES_DEF];
  logic [31:0] tbl_stamp [pmc_pkg::ENTRIES_DEF];
  int          tbl_used;
  logic [31:0] due_after;

  pmtu_op_t          ops_pending [$];
  pmc_pkg::pmc_rsp_t answers_due [$];
  pmtu_op_t          taken_op;
  pmtu_op_t          next_op;
  pmc_pkg::pmc_rsp_t want;
  logic              no_gaps;
  int unsigned       quiet_cycles;
  int unsigned       errors;

  always #2 clk = ~clk;

  task automatic flag(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic pmc_pkg::pmc_rsp_t table_answer(input pmtu_op_t op);
    pmc_pkg::pmc_rsp_t r;
    int                slot;
    logic [31:0]       elapsed;
    r    = '0;
    slot = -1;
    for (int i = tbl_used - 1; i >= 0; i--)
      if (tbl_key[i] == op.dest) slot = i;
    case (op.func)
      pmc_pkg::FN_UPDATE: begin
        r.hit = (slot >= 0);
        if (slot < 0 && tbl_used == pmc_pkg::ENTRIES_DEF) begin
          r.status = 1'b1;
        end else begin
          if (slot < 0) begin
            slot = tbl_used;
            tbl_used++;
            tbl_key[slot] = op.dest;
          end
          tbl_mtu[slot]   = op.mtu;
          tbl_stamp[slot] = op.now;
        end
      end
      pmc_pkg::FN_LOOKUP: begin
        if (slot >= 0) begin
          elapsed     = op.now - tbl_stamp[slot];
          r.hit       = 1'b1;
          r.mtu_out   = tbl_mtu[slot];
          r.probe_due = (elapsed >= due_after);
        end
      end
      pmc_pkg::FN_NEXT_LOWER: begin
        r.mtu_out = pmc_pkg::MIN_MTU;
        for (int i = pmc_pkg::PLATEAUS - 1; i >= 0; i--)
          if (pmc_pkg::PLATEAU[i] < op.mtu) r.mtu_out = pmc_pkg::PLATEAU[i];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        taken_op = '{func: req_bus.func, dest: req_bus.dest, mtu: req_bus.mtu,
                     now: req_bus.now};
        answers_due.push_back(table_answer(taken_op));
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (ops_pending.size() != 0 && (no_gaps || $urandom_range(99) >= 29)) begin
          next_op = ops_pending.pop_front();
          req_bus.valid <= 1'b1;
          req_bus.func  <= next_op.func;
          req_bus.dest  <= next_op.dest;
          req_bus.mtu   <= next_op.mtu;
          req_bus.now   <= next_op.now;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= no_gaps || ($urandom_range(99) >= 29);
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (answers_due.size() == 0) begin
          flag("response beat with no request outstanding");
        end else begin
          want = answers_due.pop_front();
          if (rsp_bus.status !== want.status)
            flag($sformatf("status %b, want %b", rsp_bus.status, want.status));
          if (rsp_bus.hit !== want.hit)
            flag($sformatf("hit %b, want %b", rsp_bus.hit, want.hit));
          if (rsp_bus.mtu_out !== want.mtu_out)
            flag($sformatf("mtu_out %0d, want %0d", rsp_bus.mtu_out, want.mtu_out));
          if (rsp_bus.probe_due !== want.probe_due)
            flag($sformatf("probe_due %b, want %b", rsp_bus.probe_due, want.probe_due));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("path_mtu_cache_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_op(input logic [1:0] func, input logic [31:0] dest,
                         input logic [15:0] mtu, input logic [31:0] now);
    ops_pending.push_back('{func: func, dest: dest, mtu: mtu, now: now});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (ops_pending.size() != 0 || req_bus.valid || answers_due.size() != 0);
  endtask

  logic [31:0] interval_plan [PHASES];
  logic [31:0] key_pool [KEY_POOL];
  logic [31:0] seen_stamp [logic [31:0]];
  logic [31:0] clock_now;
  logic [31:0] dest;
  logic [31:0] now;
  logic [15:0] mtu;
  logic [1:0]  func;
  int unsigned pick;

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    req_bus.valid = 1'b0;
    req_bus.func  = '0;
    req_bus.dest  = '0;
    req_bus.mtu   = '0;
    req_bus.now   = '0;
    rsp_bus.ready = 1'b0;
    no_gaps       = 1'b0;
    quiet_cycles  = 0;
    errors        = 0;
    tbl_used      = 0;
    due_after     = pmc_pkg::PROBE_INTERVAL_RST;

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
    interval_plan = '{32'd0, 32'hFFFF_FFFF, 32'd1, $urandom,
                      pmc_pkg::PROBE_INTERVAL_RST, $urandom_range(5000)};

    push_op(pmc_pkg::FN_LOOKUP, 32'h0, 16'h0, 32'h0);
    push_op(FN_UNDEF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    push_op(pmc_pkg::FN_NEXT_LOWER, 32'h0, 16'd0, 32'h0);
    push_op(pmc_pkg::FN_NEXT_LOWER, 32'h0, 16'd68, 32'h0);
    push_op(pmc_pkg::FN_NEXT_LOWER, 32'h0, 16'd69, 32'h0);
    push_op(pmc_pkg::FN_NEXT_LOWER, 32'h0, 16'd1492, 32'h0);
    push_op(pmc_pkg::FN_NEXT_LOWER, 32'h0, 16'd1493, 32'h0);
    push_op(pmc_pkg::FN_NEXT_LOWER, 32'h0, 16'd65534, 32'h0);
    push_op(pmc_pkg::FN_NEXT_LOWER, 32'h0, 16'd65535, 32'h0);
    push_op(pmc_pkg::FN_UPDATE, 32'h0, 16'd0, 32'h0);
    push_op(pmc_pkg::FN_LOOKUP, 32'h0, 16'd0, 32'h0);
    push_op(pmc_pkg::FN_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    push_op(pmc_pkg::FN_LOOKUP, 32'hFFFF_FFFF, 16'd0, 32'd599999);
    push_op(pmc_pkg::FN_LOOKUP, 32'hFFFF_FFFF, 16'd0, 32'd599998);
    push_op(pmc_pkg::FN_UPDATE, 32'h0, 16'd1500, 32'd100);
    push_op(pmc_pkg::FN_LOOKUP, 32'h0, 16'd0, 32'd600099);
    push_op(pmc_pkg::FN_LOOKUP, 32'h1234_5678, 16'd0, 32'd600100);
    push_op(FN_UNDEF, 32'h0, 16'd0, 32'h0);
    seen_stamp[32'h0]         = 32'd100;
    seen_stamp[32'hFFFF_FFFF] = 32'hFFFF_FFFF;
    clock_now = 32'hFFF0_0000;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clk);
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= interval_plan[ph];
      due_after = interval_plan[ph];
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
      no_gaps = (ph == 2);
      for (int n = 0; n < PHASE_OPS; n++) begin
        pick = $urandom_range(99);
        dest = ($urandom_range(9) < 8) ? key_pool[$urandom_range(KEY_POOL - 1)] : $urandom;
        clock_now += $urandom_range(5000);
        if ($urandom_range(15) == 0) clock_now += $urandom;
        now = clock_now;
        mtu = 16'($urandom);
        if (pick < 35) begin
          func = pmc_pkg::FN_UPDATE;
          if (pick < 3) mtu = 16'h0000;
          else if (pick < 6) mtu = 16'hFFFF;
          seen_stamp[dest] = now;
        end else if (pick < 75) begin
          func = pmc_pkg::FN_LOOKUP;
          // land near the probe threshold of the stored stamp
          if (seen_stamp.exists(dest) && $urandom_range(1))
            now = seen_stamp[dest] + due_after + $urandom_range(4) - 2;
        end else if (pick < 95) begin
          func = pmc_pkg::FN_NEXT_LOWER;
          if ($urandom_range(1))
            mtu = 16'(pmc_pkg::PLATEAU[$urandom_range(pmc_pkg::PLATEAUS - 1)] +
                      $urandom_range(2) - 1);
        end else begin
          func = FN_UNDEF;
        end
        push_op(func, dest, mtu, now);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (answers_due.size() != 0) flag("responses still outstanding at end of run");
    if (errors == 0) begin
      $display("path_mtu_cache_tb: PASS");
    end else begin
      $display("path_mtu_cache_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/pmc_pkg.sv
src/pmc_if.sv
src/pmc_table.sv
src/pmc_seq.sv
src/path_mtu_cache.sv
tb/path_mtu_cache_tb.sv
